// ===== hdl/hfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the histogram flatness check unit.
// ----------------------------------------------------------------------------
package hfc_pkg;

  // Flatness limit: unsigned Q0.16 fraction
  localparam int LIMIT_W = 16;
  typedef logic [LIMIT_W-1:0] limit_t;

  // Limit after reset, about 0.8
  localparam limit_t LIMIT_RESET = 16'd52429;

  // Fraction bits of the limit, the scale of the left side of the test
  localparam int FRAC_BITS = 16;

endpackage

// ===== hdl/hfc_accum.sv =====
// ----------------------------------------------------------------------------
// hfc_accum
// Running max, nonzero min, nonzero sum and nonzero bin count. On the last
// bin the updated values go to a snapshot register and the running values
// clear.
// ----------------------------------------------------------------------------
module hfc_accum import hfc_pkg::*; #(
  parameter int CW = 32,
  parameter int NW = 11,
  parameter int SW = 43,
  parameter int MAX_BINS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   visit_count,
  input  logic          last_bin,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          snap_ready,
  output logic          snap_valid,
  output logic [CW-1:0] snap_max,
  output logic [CW-1:0] snap_min,
  output logic [SW-1:0] snap_sum,
  output logic [NW-1:0] snap_bins,
  output logic          snap_empty
);

  localparam int VW = (CW > 32) ? CW : 32;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [NW-1:0] BIN_LIMIT = NW'(MAX_BINS);

  logic [CW-1:0] max_seen, max_seen_next;
  logic [CW-1:0] min_nonzero, min_nonzero_next;
  logic [SW-1:0] sum_nonzero, sum_nonzero_next;
  logic [NW-1:0] nonzero_bins, nonzero_bins_next;
  logic [VW-1:0] v_ext;
  logic [CW-1:0] v_sat;
  logic          take_bin;
  logic          accept;

  // Snapshot slot frees when the test pipeline takes it
  assign in_stall = snap_valid && !snap_ready;
  assign accept   = in_valid && !in_stall;

  // Saturate the count to the counter width
  assign v_ext = VW'(visit_count);
  assign v_sat = (v_ext > VW'(CNT_MAX)) ? CNT_MAX : v_ext[CW-1:0];

  // Accumulator update for this bin
  always_comb begin
    take_bin          = (v_sat != '0) && (nonzero_bins < BIN_LIMIT);
    max_seen_next     = max_seen;
    min_nonzero_next  = min_nonzero;
    sum_nonzero_next  = sum_nonzero;
    nonzero_bins_next = nonzero_bins;
    if (take_bin) begin
      if (v_sat > max_seen) max_seen_next = v_sat;
      if (v_sat < min_nonzero) min_nonzero_next = v_sat;
      sum_nonzero_next  = sum_nonzero + SW'(v_sat);
      nonzero_bins_next = nonzero_bins + 1'b1;
    end
  end

  // Running values; clear after the last bin
  always_ff @(posedge clk) begin
    if (rst) begin
      max_seen     <= '0;
      min_nonzero  <= CNT_MAX;
      sum_nonzero  <= '0;
      nonzero_bins <= '0;
    end else if (accept) begin
      if (last_bin) begin
        max_seen     <= '0;
        min_nonzero  <= CNT_MAX;
        sum_nonzero  <= '0;
        nonzero_bins <= '0;
      end else begin
        max_seen     <= max_seen_next;
        min_nonzero  <= min_nonzero_next;
        sum_nonzero  <= sum_nonzero_next;
        nonzero_bins <= nonzero_bins_next;
      end
    end
  end

  // Snapshot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && last_bin) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  // Snapshot payload
  always_ff @(posedge clk) begin
    if (accept && last_bin) begin
      snap_max   <= max_seen_next;
      snap_min   <= min_nonzero_next;
      snap_sum   <= sum_nonzero_next;
      snap_bins  <= nonzero_bins_next;
      snap_empty <= (nonzero_bins_next == '0);
    end
  end

endmodule

// ===== hdl/hfc_test.sv =====
// ----------------------------------------------------------------------------
// hfc_test
// Division-free flatness test on a histogram snapshot, three stages:
// products, deviation, final compare into the result register.
// ----------------------------------------------------------------------------
module hfc_test import hfc_pkg::*; #(
  parameter int CW = 32,
  parameter int NW = 11,
  parameter int SW = 43
) (
  input  logic          clk,
  input  logic          rst,
  input  limit_t        flat_limit_q16,
  input  logic          snap_valid,
  output logic          snap_ready,
  input  logic [CW-1:0] snap_max,
  input  logic [CW-1:0] snap_min,
  input  logic [SW-1:0] snap_sum,
  input  logic [NW-1:0] snap_bins,
  input  logic          snap_empty,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          is_flat,
  output logic          empty_histogram
);

  localparam int PW = CW + NW;
  localparam int LW = SW + FRAC_BITS;

  // Products stage
  logic          b_valid;
  logic [SW-1:0] b_max_n, b_min_n, b_sum;
  logic [LW-1:0] b_rhs;
  logic          b_empty;
  logic [PW-1:0] max_n_full, min_n_full;

  // Deviation stage
  logic          c_valid;
  logic [SW-1:0] c_dev, c_sum;
  logic [LW-1:0] c_rhs;
  logic          c_empty;
  logic [SW-1:0] dev_hi, dev_lo;

  // Final compare
  logic [SW-1:0] diff;
  logic [LW-1:0] lhs;
  logic          flat_next;

  logic out_free, c_free, b_free;

  // Ready chain: a stage moves when the one after it is free
  assign out_free   = !out_valid || !out_stall;
  assign c_free     = !c_valid || out_free;
  assign b_free     = !b_valid || c_free;
  assign snap_ready = b_free;

  assign max_n_full = PW'(snap_max) * PW'(snap_bins);
  assign min_n_full = PW'(snap_min) * PW'(snap_bins);

  // Deviation times the bin count, modulo the sum width
  assign dev_hi = b_max_n - b_sum;
  assign dev_lo = b_sum - b_min_n;

  // (S - devN) * 2^16 > limit * S, only when devN < S
  assign diff      = c_sum - c_dev;
  assign lhs       = {diff, {FRAC_BITS{1'b0}}};
  assign flat_next = (c_dev < c_sum) && (lhs > c_rhs);

  // Stage valids and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_free) b_valid <= snap_valid;
      if (c_free) c_valid <= b_valid;
      if (out_free) out_valid <= c_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (b_free) begin
      b_max_n <= max_n_full[SW-1:0];
      b_min_n <= min_n_full[SW-1:0];
      b_sum   <= snap_sum;
      b_rhs   <= LW'(snap_sum) * LW'(flat_limit_q16);
      b_empty <= snap_empty;
    end
    if (c_free) begin
      c_dev   <= (dev_hi > dev_lo) ? dev_hi : dev_lo;
      c_sum   <= b_sum;
      c_rhs   <= b_rhs;
      c_empty <= b_empty;
    end
    if (out_free) begin
      is_flat         <= !c_empty && flat_next;
      empty_histogram <= c_empty;
    end
  end

endmodule

// ===== hdl/histogram_flatness_check_unit.sv =====
// ----------------------------------------------------------------------------
// histogram_flatness_check_unit
// Streaming flatness check of a bin visit histogram.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------
//  input    | in_valid / in_stall    | visit_count[31:0], last_bin
//  result   | out_valid / out_stall  | is_flat, empty_histogram
//  config   | cfg_write_en           | cfg_write_data[15:0] (flatness limit)
//
// One bin is taken per clock while in_stall is low. A transaction with
// last_bin set has its result carried to the outputs through the
// snapshot, product, deviation and result registers. Each stage moves when
// the next is free; a stalled result blocks the input, last bin or not, only
// once all four registers hold a histogram. rst is synchronous, clears the
// accumulators and stage valids and restores the limit to its default.
// ----------------------------------------------------------------------------
module histogram_flatness_check_unit import hfc_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int MAX_BINS    = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [15:0]  cfg_write_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [31:0]  visit_count,
  input  logic         last_bin,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         is_flat,
  output logic         empty_histogram
);

  localparam int NW   = $clog2(MAX_BINS + 1);
  localparam int SW   = (COUNT_WIDTH + NW > 64) ? 64 : COUNT_WIDTH + NW;

  limit_t flat_limit_q16;

  logic                   snap_valid, snap_ready, snap_empty;
  logic [COUNT_WIDTH-1:0] snap_max, snap_min;
  logic [SW-1:0]          snap_sum;
  logic [NW-1:0]          snap_bins;

  // Flatness limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_limit_q16 <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      flat_limit_q16 <= cfg_write_data;
    end
  end

  hfc_accum #(
    .CW       (COUNT_WIDTH),
    .NW       (NW),
    .SW       (SW),
    .MAX_BINS (MAX_BINS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .visit_count (visit_count),
    .last_bin    (last_bin),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .snap_ready  (snap_ready),
    .snap_valid  (snap_valid),
    .snap_max    (snap_max),
    .snap_min    (snap_min),
    .snap_sum    (snap_sum),
    .snap_bins   (snap_bins),
    .snap_empty  (snap_empty)
  );

  hfc_test #(
    .CW (COUNT_WIDTH),
    .NW (NW),
    .SW (SW)
  ) u_test (
    .clk             (clk),
    .rst             (rst),
    .flat_limit_q16  (flat_limit_q16),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap_max        (snap_max),
    .snap_min        (snap_min),
    .snap_sum        (snap_sum),
    .snap_bins       (snap_bins),
    .snap_empty      (snap_empty),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_flat         (is_flat),
    .empty_histogram (empty_histogram)
  );

endmodule
